### hdl/tfsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfsq_pkg: shared types and constants of the three-queue split block
// Word formats, operation and status codes, and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tfsq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int WORD_BITS_DEFAULT   = 32;

   localparam logic [1:0] KIND_ENQUEUE      = 2'd0;
   localparam logic [1:0] KIND_DEQUEUE      = 2'd1;
   localparam logic [1:0] KIND_REDISTRIBUTE = 2'd2;

   localparam logic [1:0] QUEUE_FIRST  = 2'd0;
   localparam logic [1:0] QUEUE_SECOND = 2'd1;
   localparam logic [1:0] QUEUE_THIRD  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic [1:0]         queue_select;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data_out;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic       enqueue;
      logic       deq_capture;
      logic       pop;
      logic       redis_start;
      logic       move_write;
      logic       redis_end;
      logic       load_rsp;
      logic       rsp_take_data;
      logic [1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic q0_full;
      logic q0_empty;
      logic sel_empty;
   } dp_status_type;

endpackage
`default_nettype wire

### hdl/tfsq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfsq_datapath: queue storage, pointers and result register
// Holds the three queue memories with registered reads, the read pointers,
// fill counts and write pointer of the first queue, and the result word.
// ----------------------------------------------------------------------------
module tfsq_datapath #(
   parameter int QUEUE_DEPTH = tfsq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WORD_BITS   = tfsq_pkg::WORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tfsq_pkg::req_type      req_word,
   input  tfsq_pkg::dp_cmd_type   cmd,
   output tfsq_pkg::dp_status_type stat,
   output tfsq_pkg::rsp_type      rsp_word
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   logic signed [WORD_BITS-1:0] first_mem  [QUEUE_DEPTH];
   logic signed [WORD_BITS-1:0] second_mem [QUEUE_DEPTH];
   logic signed [WORD_BITS-1:0] third_mem  [QUEUE_DEPTH];
   logic signed [WORD_BITS-1:0] rd_ff      [3];

   logic [PTR_BITS-1:0] rp_ff  [3];
   logic [PTR_BITS-1:0] rp_in  [3];
   logic [CNT_BITS-1:0] cnt_ff [3];
   logic [CNT_BITS-1:0] cnt_in [3];
   logic [PTR_BITS-1:0] wp0_ff;
   logic [PTR_BITS-1:0] wp0_in;
   logic                odd_ff;
   logic                odd_in;
   logic [1:0]          sel_ff;
   logic [1:0]          req_sel;
   tfsq_pkg::rsp_type   rsp_ff;

   always_comb begin
      req_sel = (req_word.queue_select > tfsq_pkg::QUEUE_THIRD) ?
                tfsq_pkg::QUEUE_THIRD : req_word.queue_select;
      stat.q0_full   = (cnt_ff[0] == CNT_FULL);
      stat.q0_empty  = (cnt_ff[0] == '0);
      stat.sel_empty = (cnt_ff[req_sel] == '0);
   end

   always_comb begin
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      wp0_in = wp0_ff;
      odd_in = odd_ff;
      if (cmd.enqueue) begin
         wp0_in    = (wp0_ff == PTR_LAST) ? '0 : wp0_ff + 1'b1;
         cnt_in[0] = cnt_ff[0] + 1'b1;
      end
      if (cmd.pop) begin
         rp_in[sel_ff]  = (rp_ff[sel_ff] == PTR_LAST) ? '0 : rp_ff[sel_ff] + 1'b1;
         cnt_in[sel_ff] = cnt_ff[sel_ff] - 1'b1;
      end
      if (cmd.redis_start) begin
         rp_in[1]  = '0;
         rp_in[2]  = '0;
         cnt_in[1] = '0;
         cnt_in[2] = '0;
         odd_in    = 1'b0;
      end
      if (cmd.move_write) begin
         rp_in[0]  = (rp_ff[0] == PTR_LAST) ? '0 : rp_ff[0] + 1'b1;
         cnt_in[0] = cnt_ff[0] - 1'b1;
         odd_in    = ~odd_ff;
         if (odd_ff) begin
            cnt_in[2] = cnt_ff[2] + 1'b1;
         end else begin
            cnt_in[1] = cnt_ff[1] + 1'b1;
         end
      end
      if (cmd.redis_end) begin
         rp_in[0] = '0;
         wp0_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff  <= '{default: '0};
         cnt_ff <= '{default: '0};
         wp0_ff <= '0;
         odd_ff <= 1'b0;
      end else begin
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
         wp0_ff <= wp0_in;
         odd_ff <= odd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enqueue) begin
         first_mem[wp0_ff] <= WORD_BITS'(req_word.value);
      end
      if (cmd.move_write && !odd_ff) begin
         second_mem[cnt_ff[1][PTR_BITS-1:0]] <= rd_ff[0];
      end
      if (cmd.move_write && odd_ff) begin
         third_mem[cnt_ff[2][PTR_BITS-1:0]] <= rd_ff[0];
      end
      rd_ff[0] <= first_mem[rp_ff[0]];
      rd_ff[1] <= second_mem[rp_ff[1]];
      rd_ff[2] <= third_mem[rp_ff[2]];
   end

   always_ff @(posedge clock) begin
      if (cmd.deq_capture) begin
         sel_ff <= req_sel;
      end
      if (cmd.load_rsp) begin
         rsp_ff.data_out <= cmd.rsp_take_data ? 32'(rd_ff[sel_ff]) : '0;
         rsp_ff.status   <= cmd.rsp_status;
      end
   end

   assign rsp_word = rsp_ff;

   a_first_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff[0]) <= QUEUE_DEPTH)
      else $error("first queue count beyond its depth");

   a_split_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff[1]) + int'(cnt_ff[2]) <= QUEUE_DEPTH)
      else $error("second and third queues hold more than one queue's worth");

endmodule
`default_nettype wire

### hdl/tfsq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfsq_ctrl: controller of the three-queue split block
// Accepts request words, sequences dequeue reads and the redistribute walk,
// and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module tfsq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tfsq_pkg::req_type       req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  tfsq_pkg::dp_status_type stat,
   output tfsq_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE       = 4'b0001,
      ST_DEQ_WAIT   = 4'b0010,
      ST_MOVE_READ  = 4'b0100,
      ST_MOVE_WRITE = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_word.kind)
                  tfsq_pkg::KIND_ENQUEUE: begin
                     cmd.load_rsp = 1'b1;
                     if (stat.q0_full) begin
                        cmd.rsp_status = tfsq_pkg::STATUS_FULL;
                     end else begin
                        cmd.enqueue    = 1'b1;
                        cmd.rsp_status = tfsq_pkg::STATUS_OK;
                     end
                  end
                  tfsq_pkg::KIND_DEQUEUE: begin
                     if (stat.sel_empty) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = tfsq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd.deq_capture = 1'b1;
                        state_in        = ST_DEQ_WAIT;
                     end
                  end
                  tfsq_pkg::KIND_REDISTRIBUTE: begin
                     cmd.redis_start = 1'b1;
                     state_in        = ST_MOVE_READ;
                  end
                  default: begin
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = tfsq_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_DEQ_WAIT: begin
            cmd.pop           = 1'b1;
            cmd.load_rsp      = 1'b1;
            cmd.rsp_take_data = 1'b1;
            cmd.rsp_status    = tfsq_pkg::STATUS_OK;
            state_in          = ST_IDLE;
         end
         ST_MOVE_READ: begin
            if (stat.q0_empty) begin
               cmd.redis_end  = 1'b1;
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = tfsq_pkg::STATUS_OK;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_MOVE_WRITE;
            end
         end
         ST_MOVE_WRITE: begin
            cmd.move_write = 1'b1;
            state_in       = ST_MOVE_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a word still waiting");

   a_enqueue_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.kind == tfsq_pkg::KIND_ENQUEUE) |=> rsp_valid_ff)
      else $error("enqueue gave no result in the next cycle");

   a_dequeue_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEQ_WAIT) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("dequeue read did not complete");

endmodule
`default_nettype wire

### hdl/three_fifo_split_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_fifo_split_queue: three bounded queues with an even/odd split
// Top level joining the controller and the queue datapath.
// ----------------------------------------------------------------------------
// Each request word gives exactly one result word. An enqueue, a refused
// dequeue and an unused kind give their result in the cycle after they are
// accepted. A dequeue waits in ST_DEQ_WAIT, as the queue memories have
// registered read ports. A redistribute moves every word of the first queue
// through the single read port of the first queue memory and then writes it
// to the second or third queue. One request is in work at a time; a new one
// is taken in the cycle its predecessor's result leaves or afterwards.
module three_fifo_split_queue #(
   parameter int QUEUE_DEPTH = tfsq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WORD_BITS   = tfsq_pkg::WORD_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tfsq_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tfsq_pkg::rsp_type rsp_word
);

   tfsq_pkg::dp_cmd_type    cmd;
   tfsq_pkg::dp_status_type stat;

   tfsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tfsq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .WORD_BITS   (WORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule
`default_nettype wire
